>>> sv/mau_pkg.sv
// Package for the modular arithmetic unit: widths, operation codes, reset modulus.
// No dependencies.
package mau_pkg;
    localparam int unsigned W = 31;
    localparam int unsigned EW = 63;
    localparam int unsigned OW = 3;
    localparam logic [30:0] MOD_RESET = 31'd1000000007;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;
endpackage

>>> sv/modular_arithmetic_unit.sv
// Modular arithmetic unit: add, subtract, multiply, divide, power, negate.
// Depends on mau_pkg.
//
// One request at a time. Operands and products are reduced by a bit-serial
// restoring remainder step, one bit per cycle: it reduces each operand, reduces
// each 62-bit product, and acts as the divide unit of the Euclidean loop. Every
// modular product (a*b mod m) is one 62-bit reduction of a 31x31 multiply
// registered in the cycle before. With a nonzero modulus, every operation first
// reduces both operands; add/sub/neg then compute the result in one step;
// multiply takes one product; divide runs Euclid steps, each a divide, then one
// product; power takes one squaring product per exponent bit plus one more
// product for each set bit of the 63-bit exponent. A zero modulus returns zero
// with no arithmetic. The result sits in its own output register, so the next
// request is taken while it waits; a finished result waits in the unit until
// that register is free. The modulus is written only while the unit is idle
// and no result is pending.
module modular_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [30:0] i_operand_a,
    input  logic [30:0] i_operand_b,
    input  logic [62:0] i_exponent,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_REDA  = 10'b0000000010,
        S_REDB  = 10'b0000000100,
        S_ALU   = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_RED   = 10'b0000100000,
        S_EUC   = 10'b0001000000,
        S_EDIV  = 10'b0010000000,
        S_POW   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    // what to do after a product finishes
    typedef enum logic [2:0] {
        K_FINAL = 3'b001, K_ACC = 3'b010, K_SQ = 3'b100
    } t_kind;

    t_state      r_state, n_state;
    t_kind       r_kind;
    logic [30:0] r_mod;
    logic [2:0]  r_op;
    logic [30:0] r_a, r_b, r_acc, r_sq, r_x, r_y;
    logic [62:0] r_e;
    logic [61:0] r_num;      // dividend, shifted out MSB first
    logic [31:0] r_quo;      // quotient bits
    logic [31:0] r_rem;      // partial remainder
    logic [5:0]  r_cnt;
    // Euclid: ea, eb non-negative < 2^31; coefficients signed, bounded by m
    logic [30:0] r_ea, r_eb;
    logic signed [32:0] r_u, r_v;
    logic [30:0] r_res;
    logic [30:0] r_out;
    logic        r_ovalid;

    // shared remainder step
    logic [31:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;
    assign w_trial = {r_rem[30:0], r_num[61]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_mod};
    assign w_ge    = !w_diff[32];
    logic [31:0] w_rnext;
    assign w_rnext = w_ge ? w_diff[31:0] : w_trial;

    // Euclid divisor uses eb instead of m
    logic [32:0] w_ediff;
    logic        w_ege;
    assign w_ediff = {1'b0, w_trial} - {2'b0, r_eb};
    assign w_ege   = !w_ediff[32];

    logic signed [65:0] w_qv;
    logic signed [32:0] w_nu;
    assign w_qv = $signed({1'b0, r_quo}) * r_v;
    assign w_nu = r_u - w_qv[32:0];

    logic [31:0] w_sum;
    logic [31:0] w_sub;
    assign w_sum = {1'b0, r_a} + {1'b0, r_b};
    assign w_sub = {1'b0, r_a} + {1'b0, r_mod} - {1'b0, r_b};

    logic [32:0] w_unorm;
    assign w_unorm = r_u[32] ? (r_u + $signed({2'b0, r_mod})) : r_u;

    // move a finished result out once the output register is free
    logic        w_load_out;
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || i_ready);

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mod    <= mau_pkg::MOD_RESET;
            r_ovalid <= 1'b0;
            r_kind   <= K_FINAL;
        end else begin
            if (w_load_out) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_mod <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_operation;
                        r_e   <= i_exponent;
                        r_b   <= i_operand_b;
                        r_num <= {i_operand_a, 31'd0};
                        r_rem <= '0;
                        r_cnt <= 6'd31;
                        r_state <= (r_mod == '0) ? S_DONE : S_REDA;
                        r_res <= '0;
                    end
                end
                S_REDA: begin
                    if (r_cnt == 6'd1) begin
                        r_a <= w_rnext[30:0];
                        r_num <= {r_b, 31'd0}; r_rem <= '0; r_cnt <= 6'd31;
                        r_state <= S_REDB;
                    end else begin
                        r_rem <= w_rnext; r_num <= {r_num[60:0], 1'b0};
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_REDB: begin
                    r_rem <= w_rnext; r_num <= {r_num[60:0], 1'b0};
                    if (r_cnt == 6'd1) begin
                        r_b <= w_rnext[30:0];
                        r_state <= S_ALU;
                    end else r_cnt <= r_cnt - 6'd1;
                end
                S_ALU: begin
                    r_kind <= K_FINAL;
                    r_state <= S_DONE;
                    case (r_op)
                        mau_pkg::OP_ADD:
                            r_res <= (w_sum >= {1'b0, r_mod}) ?
                                     31'(w_sum - {1'b0, r_mod}) : w_sum[30:0];
                        mau_pkg::OP_SUB:
                            r_res <= (w_sub >= {1'b0, r_mod}) ?
                                     31'(w_sub - {1'b0, r_mod}) : w_sub[30:0];
                        mau_pkg::OP_NEG:
                            r_res <= (r_a == '0) ? '0 : 31'(r_mod - r_a);
                        mau_pkg::OP_MUL: begin
                            r_x <= r_a; r_y <= r_b; r_state <= S_MUL;
                        end
                        mau_pkg::OP_DIV: begin
                            r_ea <= r_b; r_eb <= r_mod;
                            r_u <= 33'sd1; r_v <= '0;
                            r_state <= S_EUC;
                        end
                        mau_pkg::OP_POW: begin
                            r_acc <= (r_mod == 31'd1) ? '0 : 31'd1;
                            r_sq  <= r_a;
                            r_state <= S_POW;
                        end
                        default: r_res <= '0;
                    endcase
                end
                S_MUL: begin
                    r_num <= 62'(r_x * r_y);
                    r_rem <= '0; r_cnt <= 6'd62;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_rem <= w_rnext; r_num <= {r_num[60:0], 1'b0};
                    if (r_cnt == 6'd1) begin
                        case (r_kind)
                            K_ACC: begin
                                r_acc <= w_rnext[30:0];
                                r_x <= r_sq; r_y <= r_sq; r_kind <= K_SQ;
                                r_state <= S_MUL;
                            end
                            K_SQ: begin
                                r_sq <= w_rnext[30:0];
                                r_e <= {1'b0, r_e[62:1]};
                                r_state <= S_POW;
                            end
                            default: begin
                                r_res <= w_rnext[30:0];
                                r_state <= S_DONE;
                            end
                        endcase
                    end else r_cnt <= r_cnt - 6'd1;
                end
                S_POW: begin
                    if (r_e == '0) begin
                        r_res <= r_acc; r_state <= S_DONE;
                    end else if (r_e[0]) begin
                        r_x <= r_acc; r_y <= r_sq; r_kind <= K_ACC;
                        r_state <= S_MUL;
                    end else begin
                        r_x <= r_sq; r_y <= r_sq; r_kind <= K_SQ;
                        r_state <= S_MUL;
                    end
                end
                S_EUC: begin
                    if (r_eb == '0) begin
                        // normalize u into 0..m-1 (|u| <= m), then a*u mod m
                        r_x <= r_a;
                        r_y <= (w_unorm[30:0] == r_mod) ? '0 : w_unorm[30:0];
                        r_kind <= K_FINAL;
                        r_state <= S_MUL;
                    end else begin
                        r_num <= {r_ea, 31'd0}; r_rem <= '0;
                        r_quo <= '0; r_cnt <= 6'd31;
                        r_state <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    r_rem <= w_ege ? w_ediff[31:0] : w_trial;
                    r_quo <= {r_quo[30:0], w_ege};
                    r_num <= {r_num[60:0], 1'b0};
                    if (r_cnt == 6'd0) begin
                        r_ea <= r_eb;
                        r_eb <= r_rem[30:0];
                        r_u <= r_v; r_v <= w_nu;
                        r_state <= S_EUC;
                    end else r_cnt <= r_cnt - 6'd1;
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb n_state = r_state;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_mod != '0) |-> (r_out < r_mod))
        else $error("result not reduced");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_out)))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_state != S_IDLE) |-> !o_cfg_ready)
        else $error("config taken while busy");
endmodule
